[design/assert_macros.svh]
// Assertion macros used by the top-level RTL file of the packed handle table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, ignored while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, ignored while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[design/pht_pkg.sv]
// Package: types, codes and constants of the packed handle table.
`default_nettype none
package pht_pkg;

  localparam int PHT_SLOTS = 256;
  localparam int HANDLE_W  = 32;
  localparam int VALUE_W   = 32;
  localparam int SLOT_FW   = 16;

  localparam logic [1:0] CMD_CREATE = 2'd0;
  localparam logic [1:0] CMD_SET    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [1:0] STS_OK   = 2'd0;
  localparam logic [1:0] STS_FULL = 2'd1;
  localparam logic [1:0] STS_BAD  = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_MOVE,
    ST_FREE
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic accept;
    logic exec_create;
    logic exec_set;
    logic fetch_last;
    logic move;
    logic release_slot;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic       clear_last;
    logic [1:0] op;
    logic       create_ok;
    logic       handle_ok;
  } dp_status_t;

endpackage
`default_nettype wire

[design/packed_handle_table.sv]
// Top level of the packed handle table: controller plus datapath.
// Sequence: an accepted item reads the slot memories; the check state finishes create,
// set, cmd 3 and a rejected remove, while a good remove goes on through the last-record
// read, move writeback and slot release through the shared memories. The result strobe
// is registered after the finishing state; a new item is taken only while busy is low.
// Reset: a clearing pass over all SLOTS slots initializes the slot memories; busy is high
// until it ends. The result strobe lasts one cycle; the receiver cannot stall.
`default_nettype none
`include "assert_macros.svh"
module packed_handle_table import pht_pkg::*; #(
  parameter int SLOTS = PHT_SLOTS,
  localparam int CW = $clog2(SLOTS + 1)
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          in_cmd,
  input  wire logic [HANDLE_W-1:0] in_handle,
  input  wire logic [VALUE_W-1:0]  in_value_x,
  input  wire logic [VALUE_W-1:0]  in_value_y,
  output logic                     out_valid,
  output logic [HANDLE_W-1:0]      out_new_handle,
  output logic [1:0]               out_status,
  output logic [CW-1:0]            out_live_count
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  // sequence each beat: accept, check, then move and release for a good remove
  pht_ctrl u_ctrl (
    .clk, .rst_n, .start, .sts, .busy, .cmd
  );

  // hold the tables, free list and the registered result beat
  pht_dp #(.SLOTS(SLOTS)) u_dp (
    .clk, .rst_n, .cmd,
    .in_cmd, .in_handle, .in_value_x, .in_value_y,
    .sts,
    .out_valid, .out_new_handle, .out_status, .out_live_count
  );

  // an accepted beat keeps the block busy in the next cycle
  `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  // a result beat never repeats in the following cycle
  `ASSERT_NEXT(a_one_beat, clk, rst_n, out_valid, !out_valid)
  // a failed item never hands out a handle
  `ASSERT_IMPL(a_fail_no_handle, clk, rst_n, out_valid && out_status != STS_OK,
               out_new_handle == '0)
  // a full report comes only with a full table
  `ASSERT_IMPL(a_full_count, clk, rst_n, out_valid && out_status == STS_FULL,
               out_live_count == CW'(SLOTS))

endmodule
`default_nettype wire

[design/pht_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[design/pht_ctrl.sv]
// Controller state machine of the packed handle table.
`default_nettype none
module pht_ctrl import pht_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire dp_status_t sts,
  output logic            busy,
  output ctrl_cmd_t       cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (sts.clear_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (start) state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (sts.op == CMD_REMOVE && sts.handle_ok) state_nxt = ST_MOVE;
        else state_nxt = ST_IDLE;
      end
      ST_MOVE:  state_nxt = ST_FREE;
      ST_FREE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      ST_CLEAR: cmd.clear_step = 1'b1;
      ST_IDLE: begin
        busy       = 1'b0;
        cmd.accept = start;
      end
      ST_CHECK: begin
        cmd.exec_create = (sts.op == CMD_CREATE);
        cmd.exec_set    = (sts.op == CMD_SET);
        if (sts.op == CMD_REMOVE && sts.handle_ok) cmd.fetch_last = 1'b1;
        else cmd.finish = 1'b1;
      end
      ST_MOVE: cmd.move = 1'b1;
      ST_FREE: begin
        cmd.release_slot = 1'b1;
        cmd.finish       = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

[design/pht_dp.sv]
// Datapath of the packed handle table: slot and dense memories, free list, count.
`default_nettype none
module pht_dp import pht_pkg::*; #(
  parameter int SLOTS = PHT_SLOTS,
  localparam int SW = $clog2(SLOTS),
  localparam int CW = $clog2(SLOTS + 1)
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ctrl_cmd_t           cmd,
  input  wire logic [1:0]          in_cmd,
  input  wire logic [HANDLE_W-1:0] in_handle,
  input  wire logic [VALUE_W-1:0]  in_value_x,
  input  wire logic [VALUE_W-1:0]  in_value_y,
  output dp_status_t               sts,
  output logic                     out_valid,
  output logic [HANDLE_W-1:0]      out_new_handle,
  output logic [1:0]               out_status,
  output logic [CW-1:0]            out_live_count
);

  localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

  logic [SW-1:0]       clr_idx_r;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       head_r, head_nxt;
  logic [SW-1:0]       tail_r, tail_nxt;
  logic [1:0]          op_r;
  logic [HANDLE_W-1:0] h_r;
  logic [VALUE_W-1:0]  x_r, y_r;
  logic [SW-1:0]       slot_r;
  logic [CW-1:0]       pos_r;
  logic                out_valid_r;
  logic [HANDLE_W-1:0] out_handle_r;
  logic [1:0]          out_status_r;
  logic [CW-1:0]       out_count_r;

  logic [SW-1:0]       slot_raddr, dense_raddr;
  logic [CW-1:0]       last;
  logic [HANDLE_W-1:0] hdl_q, hdl_wdata, bumped;
  logic [CW-1:0]       pos_q, pos_wdata, nxt_q, nxt_wdata;
  logic [VALUE_W-1:0]  dx_q, dy_q, dx_wdata, dy_wdata;
  logic [SW-1:0]       own_q, own_wdata;
  logic [SW-1:0]       hdl_waddr, pos_waddr, nxt_waddr, dense_waddr;
  logic                hdl_we, pos_we, nxt_we, dense_we, own_we;
  logic                create_ok, handle_ok;
  logic [1:0]          res_status;

  assign last       = count_r - CW'(1);
  assign slot_raddr = (in_cmd == CMD_CREATE) ? head_r[SW-1:0] : in_handle[SW-1:0];
  assign dense_raddr = last[SW-1:0];
  assign bumped     = {hdl_q[HANDLE_W-1:SLOT_FW] + (HANDLE_W-SLOT_FW)'(1), hdl_q[SLOT_FW-1:0]};

  assign create_ok = (count_r < SLOTS_C) && (head_r < SLOTS_C);
  assign handle_ok = ({1'b0, h_r[SLOT_FW-1:0]} < (SLOT_FW+1)'(SLOTS)) &&
                     (pos_q < SLOTS_C) && (hdl_q == h_r);

  // the create path bumps the generation read from the slot itself
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r <= in_cmd;
      x_r  <= in_value_x;
      y_r  <= in_value_y;
      h_r  <= (in_cmd == CMD_CREATE) ? '0 : in_handle;
    end else if (cmd.exec_create) begin
      h_r <= hdl_q;
    end
    if (cmd.fetch_last) begin
      slot_r <= h_r[SW-1:0];
      pos_r  <= pos_q;
    end
  end

  always_comb begin
    hdl_we = 1'b0; hdl_waddr = clr_idx_r; hdl_wdata = HANDLE_W'(clr_idx_r);
    pos_we = 1'b0; pos_waddr = clr_idx_r; pos_wdata = SLOTS_C;
    nxt_we = 1'b0; nxt_waddr = clr_idx_r; nxt_wdata = CW'(clr_idx_r) + CW'(1);
    dense_we = 1'b0; own_we = 1'b0; dense_waddr = count_r[SW-1:0];
    dx_wdata = x_r; dy_wdata = y_r; own_wdata = head_r[SW-1:0];
    if (cmd.clear_step) begin
      hdl_we = 1'b1; pos_we = 1'b1; nxt_we = 1'b1;
    end
    if (cmd.exec_create && create_ok) begin
      hdl_we    = 1'b1;
      hdl_waddr = head_r[SW-1:0];
      hdl_wdata = bumped;
      pos_we    = 1'b1;
      pos_waddr = head_r[SW-1:0];
      pos_wdata = count_r;
      dense_we  = 1'b1;
      own_we    = 1'b1;
    end
    // set rewrites the pair only; the owner stays
    if (cmd.exec_set && handle_ok) begin
      dense_we    = 1'b1;
      dense_waddr = pos_q[SW-1:0];
    end
    if (cmd.move) begin
      dense_we    = 1'b1;
      own_we      = 1'b1;
      dense_waddr = pos_r[SW-1:0];
      dx_wdata    = dx_q;
      dy_wdata    = dy_q;
      own_wdata   = own_q;
      pos_we      = 1'b1;
      pos_waddr   = own_q;
      pos_wdata   = pos_r;
      nxt_we      = (count_r < SLOTS_C);
      nxt_waddr   = tail_r;
      nxt_wdata   = CW'(slot_r);
    end
    if (cmd.release_slot) begin
      pos_we    = 1'b1;
      pos_waddr = slot_r;
      pos_wdata = SLOTS_C;
      nxt_we    = 1'b1;
      nxt_waddr = slot_r;
      nxt_wdata = SLOTS_C;
    end
  end

  always_comb begin
    count_nxt = count_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    if (cmd.exec_create && create_ok) begin
      count_nxt = count_r + CW'(1);
      head_nxt  = nxt_q;
    end
    if (cmd.release_slot) begin
      count_nxt = last;
      tail_nxt  = slot_r;
      if (count_r >= SLOTS_C) head_nxt = CW'(slot_r);
    end
  end

  always_comb begin
    res_status = STS_OK;
    if (!cmd.release_slot) begin
      case (op_r) inside
        CMD_CREATE:          res_status = create_ok ? STS_OK : STS_FULL;
        CMD_SET, CMD_REMOVE: res_status = handle_ok ? STS_OK : STS_BAD;
        default:             res_status = STS_OK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r   <= '0;
      count_r     <= '0;
      head_r      <= '0;
      tail_r      <= SW'(SLOTS - 1);
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear_step) clr_idx_r <= clr_idx_r + SW'(1);
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status_r <= res_status;
      out_count_r  <= count_nxt;
      out_handle_r <= (op_r == CMD_CREATE && create_ok && !cmd.release_slot) ?
                      bumped : '0;
    end
  end

  pht_ram #(.WIDTH(HANDLE_W), .DEPTH(SLOTS)) u_hdl (
    .clk, .we(hdl_we), .waddr(hdl_waddr), .wdata(hdl_wdata),
    .raddr(slot_raddr), .rdata(hdl_q));
  pht_ram #(.WIDTH(CW), .DEPTH(SLOTS)) u_pos (
    .clk, .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
    .raddr(slot_raddr), .rdata(pos_q));
  pht_ram #(.WIDTH(CW), .DEPTH(SLOTS)) u_nxt (
    .clk, .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
    .raddr(slot_raddr), .rdata(nxt_q));
  pht_ram #(.WIDTH(VALUE_W), .DEPTH(SLOTS)) u_dx (
    .clk, .we(dense_we), .waddr(dense_waddr), .wdata(dx_wdata),
    .raddr(dense_raddr), .rdata(dx_q));
  pht_ram #(.WIDTH(VALUE_W), .DEPTH(SLOTS)) u_dy (
    .clk, .we(dense_we), .waddr(dense_waddr), .wdata(dy_wdata),
    .raddr(dense_raddr), .rdata(dy_q));
  pht_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_own (
    .clk, .we(own_we), .waddr(dense_waddr), .wdata(own_wdata),
    .raddr(dense_raddr), .rdata(own_q));

  assign sts.clear_last = (clr_idx_r == SW'(SLOTS - 1));
  assign sts.op         = op_r;
  assign sts.create_ok  = create_ok;
  assign sts.handle_ok  = handle_ok;

  assign out_valid      = out_valid_r;
  assign out_new_handle = out_handle_r;
  assign out_status     = out_status_r;
  assign out_live_count = out_count_r;

endmodule
`default_nettype wire
